FILE: rtl/ucrb_pkg.sv
// Shared types and constants for the UART console ring buffers.
// No dependencies; imported by the top level and the checker.
package ucrb_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] irq_type;

   localparam mode_type MODE_LINE_RX  = 2'd0;
   localparam mode_type MODE_HOST_RD  = 2'd1;
   localparam mode_type MODE_HOST_WR  = 2'd2;
   localparam mode_type MODE_THR_TICK = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   localparam int IRQ_RX_BIT = 0;
   localparam int IRQ_TX_BIT = 1;

   localparam byte_type CH_CR = 8'h0D;
   localparam byte_type CH_LF = 8'h0A;

   // A TX entry carries a flag telling that the slot after it holds an LF
   // that was never written to the memory.
   typedef struct packed {
      logic     lf_next;
      byte_type data;
   } tx_entry_type;

   typedef struct packed {
      logic       read_valid;
      logic       line_valid;
      logic       line_from_ram;
      byte_type   line_byte;
      status_type status;
      irq_type    irq_enable;
      logic       rx_empty;
      logic       tx_empty;
      logic       rx_full;
      logic       tx_full;
   } rsp_type;

endpackage

FILE: rtl/ucrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ucrb_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/uart_console_ring_buffers.sv
// UART console RX and TX ring buffers. Uses ucrb_pkg and ucrb_ram.
// Result words are registered. Throughput: one word per cycle when not stalled;
// each word does at most one write and one read on each buffer memory, and LF
// expansion on TX uses one memory write.
// Reset (synchronous, active high) empties both buffers and clears the
// interrupt enables; buffer memories are not cleared and need no sweep.
module uart_console_ring_buffers #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ucrb_pkg::mode_type req_mode,
   input  ucrb_pkg::byte_type req_data_byte,
   input  logic               req_thr_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ucrb_pkg::byte_type rsp_read_byte,
   output logic               rsp_read_valid,
   output ucrb_pkg::byte_type rsp_line_byte,
   output logic               rsp_line_valid,
   output ucrb_pkg::status_type rsp_status,
   output ucrb_pkg::irq_type  rsp_irq_enable,
   output logic               rsp_rx_empty,
   output logic               rsp_tx_empty,
   output logic               rsp_rx_full,
   output logic               rsp_tx_full
);
   import ucrb_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int TX_W  = $bits(tx_entry_type);

   typedef logic [PTR_W-1:0] ptr_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   ptr_type rx_rd_ff, rx_rd_in, rx_wr_ff, rx_wr_in;
   ptr_type tx_rd_ff, tx_rd_in, tx_wr_ff, tx_wr_in;
   irq_type en_ff, en_in;
   logic    tx_lf_head_ff, tx_lf_head_in;
   logic    tx_chk_ff, tx_chk_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic         accept;
   logic         rx_we, rx_re, tx_we, tx_re;
   byte_type     rx_wdata, rx_rdata;
   tx_entry_type tx_wdata, tx_rdata;
   logic [TX_W-1:0] tx_rdata_raw;

   logic    rx_empty, rx_full, tx_empty, tx_full, tx_room2;
   ptr_type tx_wr1, tx_wr2;
   logic    is_lf, head_is_lf, tx_pop;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign rx_empty = (rx_rd_ff == rx_wr_ff);
   assign rx_full  = (ptr_next(rx_wr_ff) == rx_rd_ff);
   assign tx_empty = (tx_rd_ff == tx_wr_ff);
   assign tx_wr1   = ptr_next(tx_wr_ff);
   assign tx_wr2   = ptr_next(tx_wr1);
   assign tx_full  = (tx_wr1 == tx_rd_ff);
   assign tx_room2 = (tx_wr1 != tx_rd_ff) && (tx_wr2 != tx_rd_ff);
   assign is_lf    = (req_data_byte == CH_LF);
   assign tx_rdata = tx_entry_type'(tx_rdata_raw);

   // The head is an unstored LF when the last TX pop took the CR of an
   // expanded pair, either from memory or straight from the host write.
   assign head_is_lf = tx_lf_head_ff || (tx_chk_ff && tx_rdata.lf_next);

   always_comb begin
      rx_rd_in      = rx_rd_ff;
      rx_wr_in      = rx_wr_ff;
      tx_rd_in      = tx_rd_ff;
      tx_wr_in      = tx_wr_ff;
      en_in         = en_ff;
      tx_lf_head_in = tx_lf_head_ff;
      tx_chk_in     = tx_chk_ff;
      rx_we         = 1'b0;
      rx_re         = 1'b0;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      tx_pop        = 1'b0;
      rx_wdata      = (req_data_byte == CH_CR) ? CH_LF : req_data_byte;
      tx_wdata.lf_next = is_lf;
      tx_wdata.data    = is_lf ? CH_CR : req_data_byte;
      rsp_in        = '0;
      rsp_in.status = ST_OK;

      case (req_mode)
         MODE_LINE_RX: begin
            if (!rx_full) begin
               rx_we    = 1'b1;
               rx_wr_in = ptr_next(rx_wr_ff);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         MODE_HOST_RD: begin
            if (!rx_empty) begin
               rx_re             = 1'b1;
               rx_rd_in          = ptr_next(rx_rd_ff);
               rsp_in.read_valid = 1'b1;
            end else begin
               rsp_in.status = ST_EMPTY;
            end
         end
         MODE_HOST_WR: begin
            if (is_lf ? !tx_room2 : tx_full) begin
               rsp_in.status = ST_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wr_in = is_lf ? tx_wr2 : tx_wr1;
               en_in    = 2'b11;
               tx_pop   = req_thr_ready;
            end
         end
         MODE_THR_TICK: begin
            if (!tx_empty) begin
               tx_pop = 1'b1;
            end else begin
               rsp_in.status = ST_EMPTY;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase

      if (tx_pop) begin
         rsp_in.line_valid = 1'b1;
         tx_rd_in          = ptr_next(tx_rd_ff);
         if (tx_empty) begin
            // Pop of the byte being pushed by this same host write.
            rsp_in.line_byte = tx_wdata.data;
            tx_lf_head_in    = is_lf;
            tx_chk_in        = 1'b0;
         end else if (head_is_lf) begin
            rsp_in.line_byte = CH_LF;
            tx_lf_head_in    = 1'b0;
            tx_chk_in        = 1'b0;
         end else begin
            tx_re                = 1'b1;
            rsp_in.line_from_ram = 1'b1;
            tx_lf_head_in        = 1'b0;
            tx_chk_in            = 1'b1;
         end
      end

      if (req_mode == MODE_LINE_RX || req_mode == MODE_THR_TICK) begin
         en_in[IRQ_RX_BIT] = 1'b1;
         en_in[IRQ_TX_BIT] = (tx_rd_in != tx_wr_in);
      end

      rsp_in.irq_enable = en_in;
      rsp_in.rx_empty   = (rx_rd_in == rx_wr_in);
      rsp_in.tx_empty   = (tx_rd_in == tx_wr_in);
      rsp_in.rx_full    = (ptr_next(rx_wr_in) == rx_rd_in);
      rsp_in.tx_full    = (ptr_next(tx_wr_in) == tx_rd_in);
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_rd_ff      <= '0;
         rx_wr_ff      <= '0;
         tx_rd_ff      <= '0;
         tx_wr_ff      <= '0;
         en_ff         <= '0;
         tx_lf_head_ff <= 1'b0;
         tx_chk_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rx_rd_ff      <= rx_rd_in;
            rx_wr_ff      <= rx_wr_in;
            tx_rd_ff      <= tx_rd_in;
            tx_wr_ff      <= tx_wr_in;
            en_ff         <= en_in;
            tx_lf_head_ff <= tx_lf_head_in;
            tx_chk_ff     <= tx_chk_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   ucrb_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (accept && rx_we),
      .wr_addr (rx_wr_ff),
      .wr_data (rx_wdata),
      .rd_en   (accept && rx_re),
      .rd_addr (rx_rd_ff),
      .rd_data (rx_rdata)
   );

   ucrb_ram #(
      .WIDTH (TX_W),
      .DEPTH (FIFO_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (accept && tx_we),
      .wr_addr (tx_wr_ff),
      .wr_data (tx_wdata),
      .rd_en   (accept && tx_re),
      .rd_addr (tx_rd_ff),
      .rd_data (tx_rdata_raw)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_ff.read_valid ? rx_rdata : 8'h00;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_line_byte  = rsp_ff.line_from_ram ? tx_rdata.data : rsp_ff.line_byte;
   assign rsp_line_valid = rsp_ff.line_valid;
   assign rsp_status     = rsp_ff.status;
   assign rsp_irq_enable = rsp_ff.irq_enable;
   assign rsp_rx_empty   = rsp_ff.rx_empty;
   assign rsp_tx_empty   = rsp_ff.tx_empty;
   assign rsp_rx_full    = rsp_ff.rx_full;
   assign rsp_tx_full    = rsp_ff.tx_full;

endmodule

FILE: rtl/ucrb_checker.sv
// Port-level checks for uart_console_ring_buffers, bound to the top level.
// Uses ucrb_pkg for the status codes.
module ucrb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ucrb_pkg::byte_type rsp_read_byte,
   input logic               rsp_read_valid,
   input ucrb_pkg::byte_type rsp_line_byte,
   input logic               rsp_line_valid,
   input ucrb_pkg::status_type rsp_status,
   input logic               rsp_rx_empty,
   input logic               rsp_rx_full
);
   import ucrb_pkg::*;

   // A stalled result word keeps its popped bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_line_byte))
      else $error("stalled result word changed");

   // A single word pops at most one of the two buffers to one consumer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_read_valid && rsp_line_valid))
      else $error("host read and line byte in one word");

   // Any pop reports success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_valid || rsp_line_valid) |-> rsp_status == ST_OK)
      else $error("pop reported with a failure status");

   // The RX buffer cannot be empty and full at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_rx_empty && rsp_rx_full))
      else $error("RX buffer both empty and full");

   // No stall request toward the sender while the result side is empty.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("input stalled with no result waiting");

endmodule

bind uart_console_ring_buffers ucrb_checker u_ucrb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_byte  (rsp_read_byte),
   .rsp_read_valid (rsp_read_valid),
   .rsp_line_byte  (rsp_line_byte),
   .rsp_line_valid (rsp_line_valid),
   .rsp_status     (rsp_status),
   .rsp_rx_empty   (rsp_rx_empty),
   .rsp_rx_full    (rsp_rx_full)
);
